### hw/rtl/swp_pkg.sv
package swp_pkg;

   // Number of values the lookahead row can hold.
   localparam int DEPTH = 15;

   // Mode codes carried in bits 31:30 of every code word.
   localparam logic [1:0] MODE_2B = 2'd0;  // 15 values of 2 bits
   localparam logic [1:0] MODE_4B = 2'd1;  // 7 values of 4 bits
   localparam logic [1:0] MODE_7B = 2'd2;  // 4 values of 7 bits
   localparam logic [1:0] MODE_8B = 2'd3;  // 3 values of 8 bits

   // How the cells of the row move on a given cycle.
   typedef struct packed {
      logic       emit;
      logic [1:0] mode;
   } shift_ctl_type;

   // One result beat as it waits in the output queue.
   typedef struct packed {
      logic        stream_done;
      logic        run_last;
      logic [31:0] code_word;
   } rsp_beat_type;

   // Group length of a mode.
   function automatic logic [3:0] grp_len(input logic [1:0] mode);
      logic [3:0] len;
      begin
         unique case (mode)
            MODE_2B: len = 4'd15;
            MODE_4B: len = 4'd7;
            MODE_7B: len = 4'd4;
            MODE_8B: len = 4'd3;
            default: len = 4'd3;
         endcase
         return len;
      end
   endfunction

endpackage

### hw/rtl/swp_cell.sv
module swp_cell
   import swp_pkg::*;
(
   input  logic          clock,
   input  logic          take_value,  // this cell is the next free slot and a beat arrives
   input  logic [7:0]    new_value,
   input  shift_ctl_type ctl,
   input  logic [7:0]    nb3,         // view of the cell three places up
   input  logic [7:0]    nb4,
   input  logic [7:0]    nb7,
   output logic [7:0]    cur          // held value with this cycle's arrival merged in
);

   logic [7:0] val_ff;
   logic [7:0] val_in;

   assign cur = take_value ? new_value : val_ff;

   // When a word leaves, every cell pulls the value that sat as many places up as the
   // word consumed. A full-width group empties the row, so the content is then moot.
   always_comb begin
      val_in = cur;
      if (ctl.emit) begin
         unique case (ctl.mode)
            MODE_2B: val_in = cur;
            MODE_4B: val_in = nb7;
            MODE_7B: val_in = nb4;
            MODE_8B: val_in = nb3;
            default: val_in = cur;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

### hw/rtl/swp_select.sv
module swp_select
   import swp_pkg::*;
(
   input  logic [7:0]  cur [DEPTH],
   input  logic [3:0]  held,       // live values in the row, 0 to 15
   output logic [1:0]  mode,
   output logic [31:0] word,
   output logic [3:0]  used        // values this word consumes
);

   logic       fits_2b;
   logic       fits_4b;
   logic       fits_7b;
   logic       live;
   logic [3:0] len;

   // Each mode fits when every live value of its group is below its limit.
   always_comb begin
      fits_2b = 1'b1;
      fits_4b = 1'b1;
      fits_7b = 1'b1;
      live    = 1'b0;
      for (int k = 0; k < DEPTH; k++) begin
         live = 4'(k) < held;
         if (live && cur[k][7:2] != 6'd0) begin
            fits_2b = 1'b0;
         end
         if (k < 7 && live && cur[k][7:4] != 4'd0) begin
            fits_4b = 1'b0;
         end
         if (k < 4 && live && cur[k][7] != 1'b0) begin
            fits_7b = 1'b0;
         end
      end
   end

   always_comb begin
      priority if (fits_2b) begin
         mode = MODE_2B;
      end else if (fits_4b) begin
         mode = MODE_4B;
      end else if (fits_7b) begin
         mode = MODE_7B;
      end else begin
         mode = MODE_8B;
      end
   end

   assign len  = grp_len(mode);
   assign used = (len < held) ? len : held;

   // Values go most significant first; slots past the live values stay zero.
   always_comb begin
      word        = '0;
      word[31:30] = mode;
      unique case (mode)
         MODE_2B: begin
            for (int k = 0; k < 15; k++) begin
               if (4'(k) < held) word[28 - 2*k +: 2] = cur[k][1:0];
            end
         end
         MODE_4B: begin
            for (int k = 0; k < 7; k++) begin
               if (4'(k) < held) word[26 - 4*k +: 4] = cur[k][3:0];
            end
         end
         MODE_7B: begin
            for (int k = 0; k < 4; k++) begin
               if (4'(k) < held) word[23 - 7*k +: 7] = cur[k][6:0];
            end
         end
         MODE_8B: begin
            for (int k = 0; k < 3; k++) begin
               if (4'(k) < held) word[22 - 8*k +: 8] = cur[k];
            end
         end
         default: word = '0;
      endcase
   end

endmodule

### hw/rtl/swp_out_fifo.sv
module swp_out_fifo
   import swp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_beat_type push_beat,
   output logic         has_space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   rsp_beat_type slot_ff [2];
   logic [1:0]   count_ff;
   logic [1:0]   count_in;
   logic         wr_ptr_ff;
   logic         rd_ptr_ff;
   logic         pop;

   assign has_space = count_ff != 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_beat  = slot_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_beat;
      end
   end

endmodule

### hw/rtl/selector_word_packer.sv
// Packs a stream of 8-bit unsigned values into 32-bit code words.
// Input channel (req_): one value per beat in req_tdata; req_tlast marks the final
// value of the stream. Output channel (rsp_): one code word per beat in rsp_tdata,
// with the mode in bits 31:30 and the values below it, most significant first.
// rsp_tlast marks the last word that one input beat caused; rsp_tuser marks the
// final word of the stream.
// Values collect in a row of 15 cells. When the row fills, the densest mode whose
// group fits is chosen, one word is formed and the row shifts down by the group.
// Throughput: one input beat per cycle in the body of a stream, while the output
// queue has room. The beat that completes a word writes it into a two-entry output
// queue, which drives rsp. A final beat flushes the row in 1 to 5 words, one per
// cycle while the queue has room; req_tready stays low for the rest of the flush.
// When the receiver stalls, input beats keep being accepted while the queue has a
// free entry; once both entries wait, req_tready drops until one is taken.
// Reset empties the row and the queue; held values are lost.
module selector_word_packer
   import swp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] value
   input  logic        req_tlast,   // stream_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] code_word
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] stream_done
);

   logic [3:0]    cnt_ff;
   logic [3:0]    cnt_in;
   logic          flush_ff;
   logic          flush_in;
   logic          fifo_space;
   logic          acc;
   logic [3:0]    held_a;
   logic          emit;
   logic          ending;
   logic          normal;
   logic          final_word;
   logic [3:0]    used;
   logic [3:0]    left;
   logic [1:0]    mode;
   logic [31:0]   word;
   logic [7:0]    cur [DEPTH];
   shift_ctl_type ctl;
   rsp_beat_type  push_beat;
   rsp_beat_type  rsp_beat;

   assign req_tready = !flush_ff && fifo_space;
   assign acc        = req_tvalid && req_tready;
   assign held_a     = cnt_ff + 4'(acc);

   // A word leaves when the row fills, on the final beat, and on each flush cycle
   // that finds room in the queue.
   assign ending     = (acc && req_tlast) || flush_ff;
   assign normal     = acc && !req_tlast && held_a == 4'(DEPTH);
   assign emit       = normal || (acc && req_tlast) || (flush_ff && fifo_space);
   assign left       = held_a - used;
   assign final_word = emit && ending && left == 4'd0;

   assign ctl.emit = emit;
   assign ctl.mode = mode;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] nb3;
      logic [7:0] nb4;
      logic [7:0] nb7;
      if (i + 3 < DEPTH) begin : g_n3
         assign nb3 = cur[i + 3];
      end else begin : g_z3
         assign nb3 = '0;
      end
      if (i + 4 < DEPTH) begin : g_n4
         assign nb4 = cur[i + 4];
      end else begin : g_z4
         assign nb4 = '0;
      end
      if (i + 7 < DEPTH) begin : g_n7
         assign nb7 = cur[i + 7];
      end else begin : g_z7
         assign nb7 = '0;
      end
      swp_cell u_cell (
         .clock      (clock),
         .take_value (acc && cnt_ff == 4'(i)),
         .new_value  (req_tdata),
         .ctl        (ctl),
         .nb3        (nb3),
         .nb4        (nb4),
         .nb7        (nb7),
         .cur        (cur[i])
      );
   end

   swp_select u_select (
      .cur  (cur),
      .held (held_a),
      .mode (mode),
      .word (word),
      .used (used)
   );

   assign push_beat.code_word   = word;
   assign push_beat.run_last    = normal || final_word;
   assign push_beat.stream_done = final_word;

   swp_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (emit),
      .push_beat (push_beat),
      .has_space (fifo_space),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_tdata = rsp_beat.code_word;
   assign rsp_tlast = rsp_beat.run_last;
   assign rsp_tuser = rsp_beat.stream_done;

   always_comb begin
      cnt_in   = emit ? left : held_a;
      flush_in = flush_ff;
      if (emit && ending) begin
         flush_in = left != 4'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         flush_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         flush_ff <= flush_in;
      end
   end

`ifndef SYNTHESIS
   // The row never rests full: a full row always sends a word in the same cycle.
   a_row_never_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 4'(DEPTH))
      else $error("lookahead row rests full");

   // A flush in progress always has values left to send.
   a_flush_has_values: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> cnt_ff != 4'd0)
      else $error("flush active with an empty row");

   // A word is never formed without room in the output queue.
   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> fifo_space)
      else $error("word formed while the output queue is full");

   // After the final word of a stream the row is empty and input is open again.
   a_final_empties: assert property (@(posedge clock) disable iff (reset)
      final_word |=> (cnt_ff == 4'd0 && !flush_ff))
      else $error("row not empty after the final word");
`endif

endmodule
